@@ rtl/adpcmn_pkg.sv @@
package adpcmn_pkg;

    localparam int SmpW  = 8;
    localparam int CodeW = 4;
    localparam int MagW  = 3;
    localparam int IdxW  = 7;
    localparam int StepW = 15;
    // remainder / dividend width: holds 4*step and 7*step
    localparam int DivW  = 18;
    localparam int AdjW  = 5;

    localparam logic [IdxW-1:0]        IndexMax = 7'd88;
    localparam logic signed [SmpW-1:0] PredMax  = 8'sd127;
    localparam logic signed [SmpW-1:0] PredMin  = -8'sd128;

    typedef struct packed {
        logic            busy;
        logic [MagW-1:0] mag;
    } t_div_sts;

    function automatic logic [StepW-1:0] step_size(input logic [IdxW-1:0] idx);
        logic [StepW-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794; 7'd88: s = 15'd32767;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [AdjW-1:0] index_adjust(input logic [MagW-1:0] mag);
        logic signed [AdjW-1:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/adpcmn_if.sv @@
interface adpcmn_in_if
    import adpcmn_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [SmpW-1:0] linear_sample;
    logic                   block_end;

    modport source (output valid, output linear_sample, output block_end, input ready);
    modport sink   (input valid, input linear_sample, input block_end, output ready);
endinterface

interface adpcmn_out_if
    import adpcmn_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CodeW-1:0] adpcm_code;
    logic             last_in_block;

    modport source (output valid, output adpcm_code, output last_in_block, input ready);
    modport sink   (input valid, input adpcm_code, input last_in_block, output ready);
endinterface

@@ rtl/adpcm_nibble_encoder_8bit_top.sv @@
// ADPCM nibble encoder: one signed 8-bit sample in, one 4-bit code out (bit 3 sign,
// bits 2..0 magnitude), IMA step tables with an 8-bit saturating predictor. Each sample
// keeps i_smp.ready low from its beat until its write-back: the shared compare/subtract
// quotient unit tests step << k for k = 2, 1, 0, then predictor and step index are
// updated and the output register loaded. The difference is formed straight off the
// input beat, so no new sample is taken until the previous one has been written back.
// The code is registered at the write-back. A finished code waits in the output
// register, so the next sample is taken even while downstream stalls; only a second
// finished code waits for that register to drain. A beat with block_end set returns
// predictor and step index to zero after its own code is formed.
module adpcm_nibble_encoder_8bit_top
    import adpcmn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    adpcmn_in_if.sink     i_smp,
    adpcmn_out_if.source  o_code
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic signed [SmpW-1:0] r_pred, n_pred;
    logic [IdxW-1:0]        r_idx, n_idx;

    logic [DivW-1:0]  r_dvd;
    logic             r_sign;
    logic [StepW-1:0] r_step;
    logic             r_last;

    logic             r_out_valid, n_out_valid;
    logic [CodeW-1:0] r_code;
    logic             r_olast;

    logic in_acc, slot_free, wb;
    t_div_sts div_sts;
    logic [DivW-1:0] div_rem;

    logic signed [SmpW:0]   w_diff;
    logic [SmpW-1:0]        w_abs;
    logic [DivW-1:0]        w_dividend;
    logic [DivW-1:0]        w_prod;
    logic [DivW-1:0]        w_move;
    logic signed [DivW:0]   w_pred_sum;
    logic signed [SmpW-1:0] w_pred_new;
    logic signed [AdjW-1:0] w_adj;
    logic signed [IdxW+1:0] w_idx_sum;
    logic [IdxW-1:0]        w_idx_new;

    assign in_acc    = i_smp.valid && i_smp.ready;
    assign slot_free = !r_out_valid || o_code.ready;
    assign wb        = (r_state == S_RUN) && !div_sts.busy && slot_free;

    // difference straight off the input beat; |diff| <= 255 fits in 8 bits
    assign w_diff     = {i_smp.linear_sample[SmpW-1], i_smp.linear_sample}
                      - {r_pred[SmpW-1], r_pred};
    assign w_abs      = w_diff[SmpW] ? SmpW'(~w_diff + 1'b1) : SmpW'(w_diff);
    assign w_dividend = {{(DivW-SmpW-2){1'b0}}, w_abs, 2'b00};

    adpcmn_qdiv u_qdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (w_dividend),
        .i_step     (r_step),
        .o_sts      (div_sts),
        .o_rem      (div_rem)
    );

    // mag*step falls out of the divider: dividend minus remainder
    assign w_prod     = r_dvd - div_rem;
    assign w_move     = (w_prod >> 2) + {{(DivW-StepW){1'b0}}, r_step >> 3};
    assign w_pred_sum = r_sign
        ? ({{(DivW+1-SmpW){r_pred[SmpW-1]}}, r_pred} - $signed({1'b0, w_move}))
        : ({{(DivW+1-SmpW){r_pred[SmpW-1]}}, r_pred} + $signed({1'b0, w_move}));

    always_comb begin
        if (w_pred_sum > $signed({{(DivW+1-SmpW){1'b0}}, PredMax})) begin
            w_pred_new = PredMax;
        end else if (w_pred_sum < $signed({{(DivW+1-SmpW){1'b1}}, PredMin})) begin
            w_pred_new = PredMin;
        end else begin
            w_pred_new = w_pred_sum[SmpW-1:0];
        end
    end

    assign w_adj     = index_adjust(div_sts.mag);
    assign w_idx_sum = $signed({2'b00, r_idx})
                     + {{(IdxW+2-AdjW){w_adj[AdjW-1]}}, w_adj};

    always_comb begin
        if (w_idx_sum < 0) begin
            w_idx_new = '0;
        end else if (w_idx_sum > $signed({2'b00, IndexMax})) begin
            w_idx_new = IndexMax;
        end else begin
            w_idx_new = w_idx_sum[IdxW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pred      = r_pred;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_code.ready;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (wb) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_pred      = r_last ? '0 : w_pred_new;
                    n_idx       = r_last ? '0 : w_idx_new;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pred      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pred      <= n_pred;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dvd  <= w_dividend;
            r_sign <= w_diff[SmpW];
            r_step <= step_size(r_idx);
            r_last <= i_smp.block_end;
        end
        if (wb) begin
            r_code  <= {r_sign, div_sts.mag};
            r_olast <= r_last;
        end
    end

    assign i_smp.ready          = (r_state == S_IDLE);
    assign o_code.valid         = r_out_valid;
    assign o_code.adpcm_code    = r_code;
    assign o_code.last_in_block = r_olast;

endmodule

@@ rtl/adpcmn_qdiv.sv @@
// Restoring quotient unit: one compare/subtract of (step << k) per cycle, k = 2,1,0.
// A dividend of 8*step or more saturates naturally at 7.
module adpcmn_qdiv
    import adpcmn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DivW-1:0]  i_dividend,
    input  logic [StepW-1:0] i_step,
    output t_div_sts         o_sts,
    output logic [DivW-1:0]  o_rem
);

    logic [DivW-1:0] r_rem;
    logic [MagW-1:0] r_mag;
    logic [1:0]      r_cnt;
    logic            r_busy;

    logic [DivW-1:0] w_shifted;
    logic [DivW:0]   w_sub;
    logic            w_ge;

    assign w_shifted = {{(DivW-StepW){1'b0}}, i_step} << r_cnt;
    assign w_sub     = {1'b0, r_rem} - {1'b0, w_shifted};
    assign w_ge      = !w_sub[DivW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd2;
        end else if (r_busy) begin
            if (r_cnt == 2'd0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_mag <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_sub[DivW-1:0];
            end
            r_mag <= {r_mag[MagW-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.mag  = r_mag;
    assign o_rem      = r_rem;

endmodule

@@ rtl/adpcmn_chk.sv @@
module adpcmn_chk
    import adpcmn_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CodeW-1:0] i_out_code,
    input logic             i_out_last
);

    // a stalled code beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code)
                                        && $stable(i_out_last))
        else $error("output beat changed under stall");

    // block stays busy through the divide and update
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready
                                     ##1 !i_in_ready)
        else $error("input taken while a sample is in flight");

    // a new code only appears as the block finishes a sample
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("code produced without a sample in flight");

endmodule

bind adpcm_nibble_encoder_8bit_top adpcmn_chk u_adpcmn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_code.valid),
    .i_out_ready (o_code.ready),
    .i_out_code  (o_code.adpcm_code),
    .i_out_last  (o_code.last_in_block)
);
